[rtl/mnsh_pkg.sv]
// Shared types, sizes and codes for the majority node structural hash unit.
// No dependencies; mnsh_cell, the unit and the testbench refer to it by scoped names.
package mnsh_pkg;

    localparam int NODE_W       = 12;
    localparam int CODE_W       = NODE_W + 1;           // node index plus inversion bit
    localparam int OPERANDS     = 3;
    localparam int KEY_W        = OPERANDS * CODE_W;
    localparam int SORT_STEPS   = 2 * OPERANDS - 1;     // inject three, drain two
    localparam int STEP_W       = $clog2(SORT_STEPS);

    localparam int NODE_LIMIT   = 4096;
    localparam int NEXT_W       = $clog2(NODE_LIMIT + 1);

    // Table size is always a power of two, so the hash index is a mask.
    localparam int TABLE_ADDR_W = 12;
    localparam int TABLE_SLOTS  = 1 << TABLE_ADDR_W;

    // Hash: h = k ^ (k >> 17); h = (h * mult) mod 2^48; h ^= h >> 21.
    localparam int          HASH_W      = 48;
    localparam int          HASH_SHIFT1 = 17;
    localparam int          HASH_SHIFT2 = 21;
    localparam int          MULT_W      = 32;
    localparam logic [31:0] HASH_MULT   = 32'h9E37_79B1;
    localparam int          HASH_SPLIT  = 24;           // low part of the key per multiply
    localparam int          KEY_HI_W    = KEY_W - HASH_SPLIT;
    localparam int          PROD_HI_W   = HASH_W - HASH_SPLIT;

    localparam logic [1:0] ACT_MAJ = 2'd0;
    localparam logic [1:0] ACT_AND = 2'd1;
    localparam logic [1:0] ACT_OR  = 2'd2;
    localparam logic [1:0] ACT_PI  = 2'd3;

    localparam logic [1:0] OUT_SIMPLIFIED = 2'd0;
    localparam logic [1:0] OUT_FOUND      = 2'd1;
    localparam logic [1:0] OUT_NEW        = 2'd2;
    localparam logic [1:0] OUT_FULL       = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [NODE_W-1:0] first_node;
        logic              first_inverted;
        logic [NODE_W-1:0] second_node;
        logic              second_inverted;
        logic [NODE_W-1:0] third_node;
        logic              third_inverted;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] result_node;
        logic              result_inverted;
        logic [1:0]        outcome;
        logic              constant_in_use;
    } out_item_t;

    // Operand code moving along the sorting chain.
    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] code;
    } code_tok_t;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [NODE_W-1:0] node;
    } slot_t;

endpackage

[rtl/mnsh_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module mnsh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/mnsh_cell.sv]
// One cell of the insertion sort chain: keeps the smallest code it has seen
// and hands the larger one to its right neighbor. Uses mnsh_pkg.
module mnsh_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  mnsh_pkg::code_tok_t shift_in,
    output mnsh_pkg::code_tok_t shift_out,
    output mnsh_pkg::code_tok_t held
);

    mnsh_pkg::code_tok_t held_reg;
    mnsh_pkg::code_tok_t held_next;
    mnsh_pkg::code_tok_t out_reg;
    mnsh_pkg::code_tok_t out_next;

    always_comb
    begin
        held_next      = held_reg;
        out_next       = shift_in;
        out_next.valid = 1'b0;
        if (clear)
        begin
            held_next.valid = 1'b0;
        end
        else if (shift_in.valid)
        begin
            if (!held_reg.valid)
            begin
                held_next = shift_in;
            end
            else if (shift_in.code < held_reg.code)
            begin
                held_next = shift_in;
                out_next  = held_reg;
            end
            else
            begin
                out_next = shift_in;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            out_reg  <= '0;
        end
        else
        begin
            held_reg <= held_next;
            out_reg  <= out_next;
        end
    end

    assign shift_out = out_reg;
    assign held      = held_reg;

endmodule

[rtl/majority_node_structural_hash_unit.sv]
// Structural hashing front end for a majority-inverter graph. After reset the
// unit clears its 4096-slot table, one slot a cycle, with stall high. An item
// that simplifies, or asks for a primary input, goes from S_DECIDE straight to
// S_FINISH. An item that goes to the table passes the three cell sorting chain
// in S_SORT, the hash arithmetic in S_HASH0, S_HASH1 and S_HASH2 (two split
// multiplies), then S_READ, with one table read per cycle through the single RAM
// read port while probing. A finished result waits in the output register without
// blocking acceptance, but the next result holds the unit in S_FINISH while that
// register is full and stalled. Uses mnsh_pkg, mnsh_cell and mnsh_ram.
module majority_node_structural_hash_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_stall,
    input  mnsh_pkg::in_item_t  request,
    output logic                result_valid,
    input  logic                result_stall,
    output mnsh_pkg::out_item_t result
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_SORT,
        S_HASH0,
        S_HASH1,
        S_HASH2,
        S_READ,
        S_FINISH
    } state_t;

    state_t                              state_reg, state_next;
    mnsh_pkg::in_item_t                  req_reg, req_next;
    mnsh_pkg::code_tok_t                 ops_reg [mnsh_pkg::OPERANDS];
    mnsh_pkg::code_tok_t                 ops_next [mnsh_pkg::OPERANDS];
    logic [mnsh_pkg::STEP_W-1:0]         step_reg, step_next;
    logic [mnsh_pkg::KEY_W-1:0]          key_reg, key_next;
    logic [mnsh_pkg::HASH_W-1:0]         plo_reg, plo_next;
    logic [mnsh_pkg::KEY_HI_W-1:0]       khi_reg, khi_next;
    logic [mnsh_pkg::PROD_HI_W-1:0]      phi_reg, phi_next;
    logic [mnsh_pkg::TABLE_ADDR_W-1:0]   pos_reg, pos_next;
    logic [mnsh_pkg::TABLE_ADDR_W-1:0]   probe_reg, probe_next;
    logic [mnsh_pkg::TABLE_ADDR_W-1:0]   clr_reg, clr_next;
    logic [mnsh_pkg::NEXT_W-1:0]         next_node_reg, next_node_next;
    logic                                const_reg, const_next;
    mnsh_pkg::out_item_t                 pend_reg, pend_next;
    mnsh_pkg::out_item_t                 res_reg, res_next;
    logic                                res_valid_reg, res_valid_next;

    // sorting chain
    mnsh_pkg::code_tok_t                 chain [mnsh_pkg::OPERANDS + 1];
    mnsh_pkg::code_tok_t                 held [mnsh_pkg::OPERANDS];
    logic                                cell_clear;

    // table port
    logic                                ram_we;
    logic [mnsh_pkg::TABLE_ADDR_W-1:0]   ram_waddr;
    logic [mnsh_pkg::TABLE_ADDR_W-1:0]   ram_raddr;
    mnsh_pkg::slot_t                     ram_wdata;
    mnsh_pkg::slot_t                     rd_slot;

    // combinational helpers
    logic [mnsh_pkg::CODE_W-1:0]         c1, c2, c3, a, b, c;
    logic [mnsh_pkg::KEY_W-1:0]          key_sorted, key_mix;
    logic [mnsh_pkg::HASH_SPLIT+mnsh_pkg::MULT_W-1:0]   prod_lo;
    logic [mnsh_pkg::KEY_HI_W+mnsh_pkg::MULT_W-1:0]     prod_hi;
    logic [mnsh_pkg::HASH_W-1:0]         hash_sum, hash_fold;
    logic                                node_room;

    assign cell_clear = (state_reg == S_DECIDE);
    assign chain[0]   = ops_reg[0];

    for (genvar i = 0; i < mnsh_pkg::OPERANDS; i++)
    begin : g_cell
        mnsh_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .clear     (cell_clear),
            .shift_in  (chain[i]),
            .shift_out (chain[i+1]),
            .held      (held[i])
        );
    end

    mnsh_ram #(
        .WIDTH ($bits(mnsh_pkg::slot_t)),
        .DEPTH (mnsh_pkg::TABLE_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (rd_slot)
    );

    assign c1 = {req_reg.first_node, req_reg.first_inverted};
    assign c2 = {req_reg.second_node, req_reg.second_inverted};
    assign c3 = {req_reg.third_node, req_reg.third_inverted};

    // AND / OR put the constant node in front, inverted for OR
    always_comb
    begin
        if (req_reg.action == mnsh_pkg::ACT_MAJ)
        begin
            a = c1;
            b = c2;
            c = c3;
        end
        else
        begin
            a = {{mnsh_pkg::NODE_W{1'b0}}, req_reg.action == mnsh_pkg::ACT_OR};
            b = c1;
            c = c2;
        end
    end

    // smallest code goes to the high end of the key
    assign key_sorted = {held[0].code, held[1].code, held[2].code};
    assign key_mix    = key_sorted ^ (key_sorted >> mnsh_pkg::HASH_SHIFT1);
    assign prod_lo    = (mnsh_pkg::HASH_SPLIT + mnsh_pkg::MULT_W)'(
                            key_mix[mnsh_pkg::HASH_SPLIT-1:0])
                      * (mnsh_pkg::HASH_SPLIT + mnsh_pkg::MULT_W)'(mnsh_pkg::HASH_MULT);
    assign prod_hi    = (mnsh_pkg::KEY_HI_W + mnsh_pkg::MULT_W)'(khi_reg)
                      * (mnsh_pkg::KEY_HI_W + mnsh_pkg::MULT_W)'(mnsh_pkg::HASH_MULT);
    assign hash_sum   = plo_reg + {phi_reg, {mnsh_pkg::HASH_SPLIT{1'b0}}};
    assign hash_fold  = hash_sum ^ (hash_sum >> mnsh_pkg::HASH_SHIFT2);

    assign node_room  = (next_node_reg < mnsh_pkg::NEXT_W'(mnsh_pkg::NODE_LIMIT));

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        ops_next       = ops_reg;
        step_next      = step_reg;
        key_next       = key_reg;
        plo_next       = plo_reg;
        khi_next       = khi_reg;
        phi_next       = phi_reg;
        pos_next       = pos_reg;
        probe_next     = probe_reg;
        clr_next       = clr_reg;
        next_node_next = next_node_reg;
        const_next     = const_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = '0;
        ram_raddr = pos_reg;

        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == mnsh_pkg::TABLE_ADDR_W'(mnsh_pkg::TABLE_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (request_valid)
                begin
                    req_next   = request;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                pend_next                 = '0;
                pend_next.outcome         = mnsh_pkg::OUT_SIMPLIFIED;
                state_next                = S_FINISH;
                if (req_reg.action == mnsh_pkg::ACT_PI)
                begin
                    if (node_room)
                    begin
                        pend_next.result_node = next_node_reg[mnsh_pkg::NODE_W-1:0];
                        pend_next.outcome     = mnsh_pkg::OUT_NEW;
                        next_node_next        = next_node_reg + 1'b1;
                    end
                    else
                    begin
                        pend_next.outcome = mnsh_pkg::OUT_FULL;
                    end
                end
                else
                begin
                    if (req_reg.action != mnsh_pkg::ACT_MAJ)
                    begin
                        const_next = 1'b1;
                    end
                    priority if (a == b || a == c || b == (c ^ 1'b1))
                    begin
                        {pend_next.result_node, pend_next.result_inverted} = a;
                    end
                    else if (b == c || a == (c ^ 1'b1))
                    begin
                        {pend_next.result_node, pend_next.result_inverted} = b;
                    end
                    else if (a == (b ^ 1'b1))
                    begin
                        {pend_next.result_node, pend_next.result_inverted} = c;
                    end
                    else
                    begin
                        ops_next[0] = '{valid: 1'b1, code: a};
                        ops_next[1] = '{valid: 1'b1, code: b};
                        ops_next[2] = '{valid: 1'b1, code: c};
                        step_next   = '0;
                        state_next  = S_SORT;
                    end
                end
            end

            S_SORT:
            begin
                for (int i = 0; i < mnsh_pkg::OPERANDS - 1; i++)
                begin
                    ops_next[i] = ops_reg[i+1];
                end
                ops_next[mnsh_pkg::OPERANDS-1].valid = 1'b0;
                step_next = step_reg + 1'b1;
                if (step_reg == mnsh_pkg::STEP_W'(mnsh_pkg::SORT_STEPS - 1))
                begin
                    state_next = S_HASH0;
                end
            end

            S_HASH0:
            begin
                key_next   = key_sorted;
                plo_next   = prod_lo[mnsh_pkg::HASH_W-1:0];
                khi_next   = key_mix[mnsh_pkg::KEY_W-1:mnsh_pkg::HASH_SPLIT];
                state_next = S_HASH1;
            end

            S_HASH1:
            begin
                phi_next   = prod_hi[mnsh_pkg::PROD_HI_W-1:0];
                state_next = S_HASH2;
            end

            S_HASH2:
            begin
                pos_next   = hash_fold[mnsh_pkg::TABLE_ADDR_W-1:0];
                ram_raddr  = pos_next;
                probe_next = '0;
                state_next = S_READ;
            end

            S_READ:
            begin
                pend_next = '0;
                if (!rd_slot.valid)
                begin
                    state_next = S_FINISH;
                    if (node_room)
                    begin
                        ram_we                = 1'b1;
                        ram_wdata.valid       = 1'b1;
                        ram_wdata.key         = key_reg;
                        ram_wdata.node        = next_node_reg[mnsh_pkg::NODE_W-1:0];
                        pend_next.result_node = next_node_reg[mnsh_pkg::NODE_W-1:0];
                        pend_next.outcome     = mnsh_pkg::OUT_NEW;
                        next_node_next        = next_node_reg + 1'b1;
                    end
                    else
                    begin
                        pend_next.outcome = mnsh_pkg::OUT_FULL;
                    end
                end
                else if (rd_slot.key == key_reg)
                begin
                    pend_next.result_node = rd_slot.node;
                    pend_next.outcome     = mnsh_pkg::OUT_FOUND;
                    state_next            = S_FINISH;
                end
                else if (probe_reg == mnsh_pkg::TABLE_ADDR_W'(mnsh_pkg::TABLE_SLOTS - 1))
                begin
                    // every slot holds some other triple
                    pend_next.outcome = mnsh_pkg::OUT_FULL;
                    state_next        = S_FINISH;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    ram_raddr  = pos_next;
                end
            end

            S_FINISH:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_next                 = pend_reg;
                    res_next.constant_in_use = const_reg;
                    res_valid_next           = 1'b1;
                    state_next               = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            req_reg       <= '0;
            ops_reg       <= '{default: '0};
            step_reg      <= '0;
            key_reg       <= '0;
            plo_reg       <= '0;
            khi_reg       <= '0;
            phi_reg       <= '0;
            pos_reg       <= '0;
            probe_reg     <= '0;
            clr_reg       <= '0;
            next_node_reg <= mnsh_pkg::NEXT_W'(1);
            const_reg     <= 1'b0;
            pend_reg      <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            req_reg       <= req_next;
            ops_reg       <= ops_next;
            step_reg      <= step_next;
            key_reg       <= key_next;
            plo_reg       <= plo_next;
            khi_reg       <= khi_next;
            phi_reg       <= phi_next;
            pos_reg       <= pos_next;
            probe_reg     <= probe_next;
            clr_reg       <= clr_next;
            next_node_reg <= next_node_next;
            const_reg     <= const_next;
            pend_reg      <= pend_next;
            res_reg       <= res_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign request_stall = (state_reg != S_IDLE);
    assign result_valid  = res_valid_reg;
    assign result        = res_reg;

    // chain must hand over a strictly ascending triple
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_HASH0 |-> held[0].valid && held[1].valid && held[2].valid
            && held[0].code < held[1].code && held[1].code < held[2].code)
        else $error("sort chain not ordered at hash start");

    // node counter only steps up by one and never passes the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (next_node_reg == $past(next_node_reg)
                  || next_node_reg == $past(next_node_reg) + 1'b1)
              && next_node_reg <= mnsh_pkg::NEXT_W'(mnsh_pkg::NODE_LIMIT))
        else $error("node counter jumped");

    // a new table entry always consumes a node number
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && ram_we) |=> next_node_reg == $past(next_node_reg) + 1'b1)
        else $error("insert without node allocation");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(const_reg))
        else $error("constant flag cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.outcome == mnsh_pkg::OUT_FULL
                         || result.outcome == mnsh_pkg::OUT_NEW
                         || result.outcome == mnsh_pkg::OUT_FOUND)
            |-> !result.result_inverted)
        else $error("table or full result carries inversion");

endmodule

[tb/sv/majority_node_structural_hash_unit_tb.sv]
// Self-checking testbench for majority_node_structural_hash_unit: directed and random requests
// are checked against a behavioral hash-table predictor kept in a scoreboard class.
// Depends on mnsh_pkg (item types, action and outcome codes) and the unit's RTL.
module majority_node_structural_hash_unit_tb;

    localparam int SLOT_COUNT       = 4096;
    localparam int NODE_CAP         = 4096;
    localparam int CYCLE_LIMIT      = 600000;
    localparam int RANDOM_ITEMS     = 1250;
    localparam int HOLD_AT          = 300;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 40;
    localparam int REPORT_MAX       = 10;

    class hash_scoreboard;
        bit                  slot_used [SLOT_COUNT];
        logic [38:0]         slot_key  [SLOT_COUNT];
        logic [11:0]         slot_node [SLOT_COUNT];
        int unsigned         next_num;
        bit                  const_seen;
        mnsh_pkg::out_item_t expected_q [$];
        int                  errors;

        function new();
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                slot_used[i] = 1'b0;
            end
            next_num   = 1;
            const_seen = 1'b0;
            errors     = 0;
        endfunction

        function int unsigned home_slot(logic [38:0] key);
            logic [63:0] h;
            h = 64'(key) ^ (64'(key) >> 17);
            h = (h * 64'h9E37_79B1) & 64'hFFFF_FFFF_FFFF;
            h = h ^ (h >> 21);
            return int'(h % 64'(SLOT_COUNT));
        endfunction

        function void note_request(mnsh_pkg::in_item_t req);
            logic [12:0]         a, b, c, t, r;
            logic [38:0]         key;
            int unsigned         pos, probes;
            bit                  done, have_empty, hit;
            mnsh_pkg::out_item_t e;
            e          = '0;
            have_empty = 1'b0;
            hit        = 1'b0;
            if (req.action == mnsh_pkg::ACT_PI)
            begin
                if (next_num >= NODE_CAP)
                    e.outcome = mnsh_pkg::OUT_FULL;
                else
                begin
                    e.result_node = next_num[11:0];
                    e.outcome     = mnsh_pkg::OUT_NEW;
                    next_num++;
                end
            end
            else
            begin
                if (req.action == mnsh_pkg::ACT_MAJ)
                begin
                    a = {req.first_node, req.first_inverted};
                    b = {req.second_node, req.second_inverted};
                    c = {req.third_node, req.third_inverted};
                end
                else
                begin
                    // and / or: constant node is the first majority operand
                    const_seen = 1'b1;
                    a = (req.action == mnsh_pkg::ACT_OR) ? 13'd1 : 13'd0;
                    b = {req.first_node, req.first_inverted};
                    c = {req.second_node, req.second_inverted};
                end
                done = 1'b1;
                if (a == b)                     r = a;
                else if (a == c)                r = a;
                else if (b == c)                r = b;
                else if (a == (b ^ 13'd1))      r = c;
                else if (a == (c ^ 13'd1))      r = b;
                else if (b == (c ^ 13'd1))      r = a;
                else                            done = 1'b0;
                if (done)
                begin
                    e.result_node     = r[12:1];
                    e.result_inverted = r[0];
                    e.outcome         = mnsh_pkg::OUT_SIMPLIFIED;
                end
                else
                begin
                    if (a > b) begin t = a; a = b; b = t; end
                    if (b > c) begin t = b; b = c; c = t; end
                    if (a > b) begin t = a; a = b; b = t; end
                    key    = {a, b, c};
                    pos    = home_slot(key);
                    probes = 0;
                    // linear probing until an empty slot, the same triple or a full sweep of the table
                    while (probes < SLOT_COUNT && !have_empty && !hit)
                    begin
                        if (!slot_used[pos])
                            have_empty = 1'b1;
                        else if (slot_key[pos] == key)
                            hit = 1'b1;
                        else
                        begin
                            pos = (pos + 1) % SLOT_COUNT;
                            probes++;
                        end
                    end
                    if (hit)
                    begin
                        e.result_node = slot_node[pos];
                        e.outcome     = mnsh_pkg::OUT_FOUND;
                    end
                    else if (!have_empty || next_num >= NODE_CAP)
                        e.outcome = mnsh_pkg::OUT_FULL;
                    else
                    begin
                        slot_used[pos] = 1'b1;
                        slot_key[pos]  = key;
                        slot_node[pos] = next_num[11:0];
                        e.result_node  = next_num[11:0];
                        e.outcome      = mnsh_pkg::OUT_NEW;
                        next_num++;
                    end
                end
            end
            e.constant_in_use = const_seen;
            expected_q.push_back(e);
        endfunction

        function void check_result(mnsh_pkg::out_item_t got);
            mnsh_pkg::out_item_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("unexpected result item: node %0d inv %0b outcome %0d const %0b",
                             got.result_node, got.result_inverted, got.outcome,
                             got.constant_in_use);
                return;
            end
            want = expected_q.pop_front();
            if (got.result_node !== want.result_node
                || got.result_inverted !== want.result_inverted
                || got.outcome !== want.outcome
                || got.constant_in_use !== want.constant_in_use)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("result mismatch: expected node %0d inv %0b outcome %0d const %0b, %s",
                             want.result_node, want.result_inverted, want.outcome,
                             want.constant_in_use,
                             $sformatf("got node %0d inv %0b outcome %0d const %0b",
                                       got.result_node, got.result_inverted, got.outcome,
                                       got.constant_in_use));
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                request_valid;
    logic                request_stall;
    mnsh_pkg::in_item_t  request;
    logic                result_valid;
    logic                result_stall;
    mnsh_pkg::out_item_t result;

    hash_scoreboard sb = new();
    int unsigned    node_hint;
    logic [38:0]    sent_triples [$];

    always #5 clk = ~clk;

    majority_node_structural_hash_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .request       (request),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result        (result)
    );

    always @(posedge clk)
    begin
        if (rst_n && request_valid && !request_stall)
            sb.note_request(request);
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result);
    end

    function automatic logic [12:0] opnd(int n, bit inv);
        return {n[11:0], inv};
    endfunction

    function automatic mnsh_pkg::in_item_t pack_item(logic [1:0] act, logic [12:0] c1,
                                                     logic [12:0] c2, logic [12:0] c3);
        mnsh_pkg::in_item_t it;
        it.action          = act;
        it.first_node      = c1[12:1];
        it.first_inverted  = c1[0];
        it.second_node     = c2[12:1];
        it.second_inverted = c2[0];
        it.third_node      = c3[12:1];
        it.third_inverted  = c3[0];
        return it;
    endfunction

    // Mostly small or already allocated nodes, so that triples repeat and hit.
    function automatic logic [12:0] rand_code();
        int unsigned n;
        int          r;
        r = $urandom_range(0, 9);
        if (r < 4)
            n = $urandom_range(0, 15);
        else if (r < 8)
            n = $urandom_range(0, node_hint);
        else
            n = $urandom_range(0, 4095);
        return {n[11:0], 1'($urandom_range(0, 1))};
    endfunction

    function automatic mnsh_pkg::in_item_t make_item();
        logic [12:0] o [3];
        logic [12:0] t;
        logic [38:0] k;
        int          r, i, j, p;
        for (i = 0; i < 3; i++)
            o[i] = rand_code();
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            if (node_hint < 4095)
                node_hint++;
            return pack_item(mnsh_pkg::ACT_PI, o[0], o[1], o[2]);
        end
        if (r < 28)
        begin
            if ($urandom_range(0, 3) == 0)
                o[1] = o[0] ^ 13'($urandom_range(0, 1));
            sent_triples.push_back({(r < 19) ? 13'd0 : 13'd1, o[0], o[1]});
            if (node_hint < 4095)
                node_hint++;
            return pack_item((r < 19) ? mnsh_pkg::ACT_AND : mnsh_pkg::ACT_OR,
                             o[0], o[1], o[2]);
        end
        if (r < 45 && sent_triples.size() > 0)
        begin
            // earlier triple in any operand order
            k    = sent_triples[$urandom_range(0, sent_triples.size() - 1)];
            o[0] = k[38:26];
            o[1] = k[25:13];
            o[2] = k[12:0];
            p    = $urandom_range(0, 2);
            t    = o[0]; o[0] = o[p]; o[p] = t;
            p    = $urandom_range(1, 2);
            t    = o[1]; o[1] = o[p]; o[p] = t;
        end
        else if (r < 58)
        begin
            // equal or complementary pair at random positions
            i    = $urandom_range(0, 2);
            j    = (i + $urandom_range(1, 2)) % 3;
            o[j] = o[i] ^ 13'($urandom_range(0, 1));
        end
        else
        begin
            sent_triples.push_back({o[0], o[1], o[2]});
            if (node_hint < 4095)
                node_hint++;
        end
        return pack_item(mnsh_pkg::ACT_MAJ, o[0], o[1], o[2]);
    endfunction

    task automatic send_item(mnsh_pkg::in_item_t it, int gap);
        repeat (gap)
        begin
            @(negedge clk);
            request_valid <= 1'b0;
        end
        @(negedge clk);
        request       <= it;
        request_valid <= 1'b1;
        do @(posedge clk); while (request_stall);
    endtask

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    initial
    begin : receiver
        int got, w;
        got          = 0;
        result_stall = 1'b0;
        forever
        begin
            w = ((got / 40) % 5 == 2) ? 0 : $urandom_range(0, 15);
            // one long hold-off so the unit backs up into its input
            if (got == HOLD_AT)
                w = HOLD_CYCLES;
            repeat (w)
            begin
                @(negedge clk);
                result_stall <= 1'b1;
            end
            @(negedge clk);
            result_stall <= 1'b0;
            do @(posedge clk); while (!(rst_n && result_valid));
            got++;
        end
    end

    initial
    begin : stimulus
        mnsh_pkg::in_item_t directed_items [$];
        int                 gap;
        logic [12:0]        big;
        rst_n         = 1'b0;
        request_valid = 1'b0;
        request       = '0;
        node_hint     = 0;
        big           = opnd(4095, 1);
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        directed_items.push_back(pack_item(mnsh_pkg::ACT_PI, big, big, big));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_PI, '0, '0, '0));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_PI, big, '0, big));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(1, 0), opnd(2, 0), opnd(3, 0)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(3, 0), opnd(2, 0), opnd(1, 0)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(1, 1), opnd(2, 0), opnd(3, 0)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(2, 0), opnd(2, 0), opnd(3, 1)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(2, 1), opnd(3, 0), opnd(2, 1)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(1, 0), opnd(3, 1), opnd(3, 1)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(1, 0), opnd(1, 1), opnd(3, 0)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(2, 0), opnd(3, 0), opnd(2, 1)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(1, 0), opnd(3, 0), opnd(3, 1)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_AND, opnd(1, 0), opnd(2, 0), big));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_OR, opnd(1, 0), opnd(2, 0), '0));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(2, 0), opnd(0, 0), opnd(1, 0)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_AND, opnd(0, 0), opnd(3, 0), '0));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_OR, opnd(0, 0), opnd(3, 0), '0));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_AND, big, opnd(4095, 0), big));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           big, opnd(4094, 0), opnd(0, 0)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(4095, 0), opnd(4094, 1), opnd(0, 1)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_MAJ,
                                           opnd(0, 0), opnd(4094, 0), big));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_OR,
                                           big, opnd(2048, 0), opnd(2048, 1)));
        directed_items.push_back(pack_item(mnsh_pkg::ACT_PI,
                                           opnd(2730, 1), opnd(1365, 0), opnd(2730, 1)));
        foreach (directed_items[i])
            send_item(directed_items[i], $urandom_range(0, 15));
        node_hint = 8;

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            gap = ((n / 40) % 5 == 4) ? 0 : $urandom_range(0, 15);
            send_item(make_item(), gap);
        end
        @(negedge clk);
        request_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[majority_node_structural_hash_unit.f]
rtl/mnsh_pkg.sv
rtl/mnsh_ram.sv
rtl/mnsh_cell.sv
rtl/majority_node_structural_hash_unit.sv
tb/sv/majority_node_structural_hash_unit_tb.sv
